[design/rgb_conv3x3_extremum_filter_assert.svh]
// Assertion macros shared by the filter modules.
`ifndef RGB_CONV3X3_EXTREMUM_FILTER_ASSERT_SVH
`define RGB_CONV3X3_EXTREMUM_FILTER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define RCEF_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rcef: invariant violated");

// A condition that, once seen, forces another one at the next edge.
`define RCEF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rcef: sequence violated");

`endif

[design/rcef_pkg.sv]
package rcef_pkg;

  // Default largest image side.
  localparam int RCEF_MAX_SIZE = 1024;
  // Smallest accepted image side.
  localparam logic [10:0] RCEF_MIN_SIZE = 11'd3;
  // Width of a colour sum over the window.
  localparam int SUMW = 21;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_SIZE = 3'd0,
    REG_KTOP = 3'd1,
    REG_KMID = 3'd2,
    REG_KBOT = 3'd3,
    REG_DIV  = 3'd4,
    REG_EXT  = 3'd5
  } reg_idx_t;

  // Current register contents.
  typedef struct packed {
    logic [10:0] size;
    logic [23:0] ktop;
    logic [23:0] kmid;
    logic [23:0] kbot;
    logic [7:0]  div;
    logic        ext;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       upd;
    logic       mac;
    logic [3:0] tap;
    logic       ext;
    logic       dinit;
    logic       dstep;
    logic       push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic interior;
    logic out_busy;
  } sts_t;

  // One colour channel of a packed pixel.
  function automatic logic [7:0] chan(input logic [23:0] px, input logic [1:0] ch);
    logic [7:0] v;
    unique case (ch)
      2'd0:    v = px[7:0];
      2'd1:    v = px[15:8];
      default: v = px[23:16];
    endcase
    return v;
  endfunction

  // Kernel coefficient of a window position, raster order.
  function automatic logic signed [7:0] coef_sel(input cfg_t c, input logic [3:0] tap);
    logic [7:0] v;
    unique case (tap)
      4'd0:    v = c.ktop[7:0];
      4'd1:    v = c.ktop[15:8];
      4'd2:    v = c.ktop[23:16];
      4'd3:    v = c.kmid[7:0];
      4'd4:    v = c.kmid[15:8];
      4'd5:    v = c.kmid[23:16];
      4'd6:    v = c.kbot[7:0];
      4'd7:    v = c.kbot[15:8];
      default: v = c.kbot[23:16];
    endcase
    return signed'(v);
  endfunction

endpackage

[design/rcef_regs.sv]
module rcef_regs
  import rcef_pkg::*;
#(
  parameter int MAX_SIZE = RCEF_MAX_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg,
  output logic        size_wr,
  output logic [10:0] size_val
);

  logic     wr;
  reg_idx_t idx;
  logic [10:0] raw;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign raw    = pwdata[10:0];

  // The image side is clamped into the supported range on write.
  always_comb begin
    if (raw < RCEF_MIN_SIZE) begin
      size_val = RCEF_MIN_SIZE;
    end else if (32'(raw) > MAX_SIZE) begin
      size_val = 11'(MAX_SIZE);
    end else begin
      size_val = raw;
    end
  end

  assign size_wr = wr && (idx == REG_SIZE);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size <= RCEF_MIN_SIZE;
      cfg.ktop <= '0;
      cfg.kmid <= '0;
      cfg.kbot <= '0;
      cfg.div  <= 8'd1;
      cfg.ext  <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_SIZE: cfg.size <= size_val;
        REG_KTOP: cfg.ktop <= pwdata[23:0];
        REG_KMID: cfg.kmid <= pwdata[23:0];
        REG_KBOT: cfg.kbot <= pwdata[23:0];
        REG_DIV:  cfg.div  <= pwdata[7:0];
        REG_EXT:  cfg.ext  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back.
  always_comb begin
    unique case (idx)
      REG_SIZE: prdata = 32'(cfg.size);
      REG_KTOP: prdata = 32'(cfg.ktop);
      REG_KMID: prdata = 32'(cfg.kmid);
      REG_KBOT: prdata = 32'(cfg.kbot);
      REG_DIV:  prdata = 32'(cfg.div);
      REG_EXT:  prdata = 32'(cfg.ext);
      default:  prdata = '0;
    endcase
  end

endmodule

[design/rcef_ctrl.sv]
module rcef_ctrl
  import rcef_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_MAC, S_EXT, S_DINIT, S_DIV, S_OUT
  } state_t;

  state_t     state;
  logic [3:0] step;

  assign in_ready = (state == S_IDLE);

  // Commands follow from the state and the step count.
  always_comb begin
    cmd       = '0;
    cmd.upd   = (state == S_UPD);
    cmd.mac   = (state == S_MAC);
    cmd.tap   = step;
    cmd.ext   = (state == S_EXT);
    cmd.dinit = (state == S_DINIT);
    cmd.dstep = (state == S_DIV);
    cmd.push  = (state == S_OUT);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_UPD;
        end
        S_UPD: begin
          step <= '0;
          if (!sts.emit) begin
            state <= S_IDLE;
          end else if (sts.interior) begin
            state <= S_MAC;
          end else begin
            state <= S_OUT;
          end
        end
        S_MAC: begin
          if (step == 4'd8) begin
            state <= S_EXT;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_EXT:   state <= S_DINIT;
        S_DINIT: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == 4'd7) begin
            state <= S_OUT;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_OUT: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "rgb_conv3x3_extremum_filter_assert.svh"

  `RCEF_ASSERT(a_mac_step, (state != S_MAC) || (step <= 4'd8))
  `RCEF_ASSERT(a_div_step, (state != S_DIV) || (step <= 4'd7))
  `RCEF_ASSERT_NEXT(a_accept_upd, (state == S_IDLE) && in_valid, state == S_UPD)

endmodule

[design/rcef_dp.sv]
module rcef_dp
  import rcef_pkg::*;
#(
  parameter int MAX_SIZE = RCEF_MAX_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        size_wr,
  input  logic [10:0] size_val,
  input  logic        acc,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        is_flush,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_end
);

  localparam int CW = $clog2(MAX_SIZE);
  localparam int SW = (CW + 1 > 11) ? CW + 1 : 11;

  // Line stores.
  logic [23:0] lsa [MAX_SIZE];
  logic [23:0] lsb [MAX_SIZE];
  logic [23:0] rda, rdb;

  logic [23:0] pix;
  logic        flush;
  logic [23:0] win [9];

  logic [SW-1:0] row, col, qrow, qcol, pending;
  logic [SW-1:0] dim, lead, ndim;
  logic [SW-1:0] col_inc, row_inc, qcol_inc, qrow_inc;
  logic          active, emit, interior, last;
  logic          fend;
  logic          interior_q;

  logic signed [SUMW-1:0] sum [3];
  logic [23:0] lo_px, hi_px;
  logic [9:0]  lo_in, hi_in, cur_in;
  logic [23:0] tap_px;
  logic signed [7:0] tap_c;
  logic [7:0]  dv;
  logic [7:0]  rem [3];
  logic [7:0]  num [3];
  logic [7:0]  quo [3];
  logic [2:0]  zero, sat;
  logic [7:0]  res [3];

  assign dim  = SW'(cfg.size);
  assign ndim = SW'(size_val);
  assign lead = dim + SW'(1);
  assign dv   = (cfg.div == 8'd0) ? 8'd1 : cfg.div;

  // Decisions for the item in hand, made before its counter update.
  assign active   = !(flush && (pending == '0));
  assign emit     = active && (flush || (pending >= lead));
  assign interior = (qrow >= SW'(1)) && (qrow + SW'(2) <= dim) &&
                    (qcol >= SW'(1)) && (qcol + SW'(2) <= dim);
  assign last     = (qrow == dim - SW'(1)) && (qcol == dim - SW'(1));

  assign sts.emit     = emit;
  assign sts.interior = interior;
  assign sts.out_busy = out_valid && !out_ready;

  // Input capture and line store read at acceptance.
  always_ff @(posedge clk) begin
    if (acc) begin
      pix   <= is_flush ? 24'd0 : {in_blue, in_green, in_red};
      flush <= is_flush;
      rda   <= lsa[col[CW-1:0]];
      rdb   <= lsb[col[CW-1:0]];
    end
  end

  // Line store write; a flush item leaves the stores alone.
  always_ff @(posedge clk) begin
    if (cmd.upd && !flush) begin
      lsa[col[CW-1:0]] <= pix;
      lsb[col[CW-1:0]] <= rda;
    end
  end

  // Window shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else if (cmd.upd && active) begin
      for (int k = 0; k < 9; k += 3) begin
        win[k]   <= win[k+1];
        win[k+1] <= win[k+2];
      end
      win[2] <= rdb;
      win[5] <= rda;
      win[8] <= pix;
    end
  end

  assign col_inc  = col + SW'(1);
  assign row_inc  = row + SW'(1);
  assign qcol_inc = qcol + SW'(1);
  assign qrow_inc = qrow + SW'(1);

  // Frame position of the input and of the result it releases.
  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      pending <= '0;
      qrow    <= SW'(1);
      qcol    <= SW'(2);
    end else if (size_wr) begin
      row     <= '0;
      col     <= '0;
      pending <= '0;
      qrow    <= ndim - SW'(2);
      qcol    <= ndim - SW'(1);
    end else if (cmd.upd && active) begin
      if (flush && (pending == SW'(1))) begin
        row  <= '0;
        col  <= '0;
        qrow <= dim - SW'(2);
        qcol <= dim - SW'(1);
      end else begin
        if (col_inc >= dim) begin
          col <= '0;
          row <= (row_inc >= dim) ? '0 : row_inc;
        end else begin
          col <= col_inc;
        end
        if (qcol_inc >= dim) begin
          qcol <= '0;
          qrow <= (qrow_inc >= dim) ? '0 : qrow_inc;
        end else begin
          qcol <= qcol_inc;
        end
      end
      if (flush) begin
        pending <= pending - SW'(1);
      end else if (!emit) begin
        pending <= pending + SW'(1);
      end
    end
  end

  // Frame end flag of the pending result.
  always_ff @(posedge clk) begin
    if (cmd.upd) fend <= last;
  end

  assign tap_px = win[cmd.tap];
  assign tap_c  = coef_sel(cfg, cmd.tap);
  assign cur_in = 10'(chan(tap_px, 2'd0)) + 10'(chan(tap_px, 2'd1)) +
                  10'(chan(tap_px, 2'd2));

  // Multiply-accumulate over the window, one tap a cycle, with the
  // intensity extremes tracked alongside.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      for (int ch = 0; ch < 3; ch++) sum[ch] <= '0;
    end else if (cmd.mac) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum[ch] <= sum[ch] +
                   SUMW'(signed'({1'b0, chan(tap_px, 2'(ch))})) * SUMW'(tap_c);
      end
      if ((cmd.tap == 4'd0) || (cur_in <= lo_in)) begin
        lo_in <= cur_in;
        lo_px <= tap_px;
      end
      if ((cmd.tap == 4'd0) || (cur_in > hi_in)) begin
        hi_in <= cur_in;
        hi_px <= tap_px;
      end
    end else if (cmd.ext && cfg.ext) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum[ch] <= sum[ch] - SUMW'(chan(lo_px, 2'(ch))) - SUMW'(chan(hi_px, 2'(ch)));
      end
    end
  end

  // Division by the scale, one quotient bit a cycle per colour.
  // Non-positive sums give zero and sums of 256 scales or more saturate,
  // so the quotient needs eight bits only.
  always_ff @(posedge clk) begin
    if (cmd.dinit) begin
      for (int ch = 0; ch < 3; ch++) begin
        zero[ch] <= (sum[ch] <= SUMW'(0));
        sat[ch]  <= (sum[ch] >= signed'(SUMW'({dv, 8'd0})));
        rem[ch]  <= sum[ch][15:8];
        num[ch]  <= sum[ch][7:0];
        quo[ch]  <= '0;
      end
    end else if (cmd.dstep) begin
      for (int ch = 0; ch < 3; ch++) begin
        if ({rem[ch], num[ch][7]} >= {1'b0, dv}) begin
          rem[ch] <= 8'({rem[ch], num[ch][7]} - {1'b0, dv});
          quo[ch] <= {quo[ch][6:0], 1'b1};
        end else begin
          rem[ch] <= {rem[ch][6:0], num[ch][7]};
          quo[ch] <= {quo[ch][6:0], 1'b0};
        end
        num[ch] <= {num[ch][6:0], 1'b0};
      end
    end
  end

  // Interior pixels take the filtered value, border pixels the centre.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (!interior_q) begin
        res[ch] = chan(win[4], 2'(ch));
      end else if (zero[ch]) begin
        res[ch] = 8'd0;
      end else if (sat[ch]) begin
        res[ch] = 8'd255;
      end else begin
        res[ch] = quo[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) interior_q <= interior;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push && !sts.out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !sts.out_busy) begin
      out_red   <= res[0];
      out_green <= res[1];
      out_blue  <= res[2];
      frame_end <= fend;
    end
  end

  `include "rgb_conv3x3_extremum_filter_assert.svh"

  `RCEF_ASSERT(a_pending_bound, pending <= lead)
  `RCEF_ASSERT(a_in_pos, (row < dim) && (col < dim))
  `RCEF_ASSERT(a_out_pos, (qrow < dim) && (qcol < dim))
  `RCEF_ASSERT_NEXT(a_push_loads, cmd.push && !sts.out_busy, out_valid)

endmodule

[design/rgb_conv3x3_extremum_filter.sv]
// Streaming 3x3 RGB convolution over a square image, with an optional
// subtraction of the brightest and darkest window pixels.
// Input channel: in_valid/in_ready carry one raster pixel per beat, or a
// flush beat (is_flush high) that pushes out one owed result.
// Output channel: out_valid/out_ready carry one result pixel per beat;
// frame_end marks the last pixel of the image.
// The result of a pixel leaves image_size+1 input beats later; after the
// last pixel of a frame, image_size+1 flush beats drain the tail.
// An input beat that releases no result passes through acceptance and the
// window update; one that releases a border pixel adds the output step; an
// interior pixel adds a multiply-accumulate step per window tap, an extremum
// step and a bit-serial division of a set-up step and a step per quotient bit.
// The output register lets the next beat be taken while a result waits;
// a stalled receiver holds the block only when a new result is ready.
// Reset (synchronous) clears counters, window and registers; the line
// stores need no clearing. Writing image_size starts a new frame.
module rgb_conv3x3_extremum_filter
  import rcef_pkg::*;
#(
  parameter int MAX_SIZE = RCEF_MAX_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        is_flush,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_end
);

  cfg_t        cfg;
  logic        size_wr;
  logic [10:0] size_val;
  cmd_t        cmd;
  sts_t        sts;

  rcef_regs #(.MAX_SIZE(MAX_SIZE)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .size_wr, .size_val
  );

  rcef_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .sts, .cmd
  );

  rcef_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk, .rst, .cfg, .size_wr, .size_val,
    .acc(in_valid && in_ready),
    .in_red, .in_green, .in_blue, .is_flush,
    .cmd, .sts,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue, .frame_end
  );

endmodule

[tb/tb_rgb_conv3x3_extremum_filter.sv]
`timescale 1ns / 1ps

module tb_rgb_conv3x3_extremum_filter
  import rcef_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [7:0]  in_red, in_green, in_blue;
  logic        is_flush;
  logic        out_valid, out_ready;
  logic [7:0]  out_red, out_green, out_blue;
  logic        frame_end;

  rgb_conv3x3_extremum_filter dut (.*);

  // Result pixel as carried on the output channel.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } pix_res_t;

  // Directed stimulus row: pixel, flush flag, a typed-in result where obvious.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fl;
    logic       known;
    pix_res_t   res;
  } dir_row_t;

  // Shadow registers of the filter.
  logic [10:0] sh_size;
  logic [23:0] sh_krow [3];
  logic [7:0]  sh_div;
  logic        sh_ext;

  // Shadow datapath state.
  logic [23:0] ls_a [1024];
  logic [23:0] ls_b [1024];
  logic [23:0] win [9];
  int unsigned row_n, col_n, owed_n;

  pix_res_t result_q [$];
  int       err_cnt;
  int       idle_cycles;
  bit       hold_off;
  bit       no_gaps;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int px_chan(logic [23:0] px, int ch);
    return int'(px[8*ch +: 8]);
  endfunction

  function automatic int kcoef(int pos);
    logic [7:0] v;
    v = sh_krow[pos / 3][8*(pos % 3) +: 8];
    return int'(signed'(v));
  endfunction

  function automatic logic [7:0] scale_clamp(int sum, int dv);
    int v;
    v = sum / dv;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Weighted window sum with optional extremum removal.
  function automatic logic [23:0] window_sum();
    int s [3];
    int dv, lo, hi, lo_i, hi_i, inten;
    logic [23:0] res;
    s = '{0, 0, 0};
    dv = (sh_div == 0) ? 1 : int'(sh_div);
    for (int k = 0; k < 9; k++)
      for (int ch = 0; ch < 3; ch++)
        s[ch] += px_chan(win[k], ch) * kcoef(k);
    if (sh_ext) begin
      lo = 766; hi = -1; lo_i = 0; hi_i = 0;
      for (int k = 0; k < 9; k++) begin
        inten = px_chan(win[k], 0) + px_chan(win[k], 1) + px_chan(win[k], 2);
        if (inten <= lo) begin lo = inten; lo_i = k; end
        if (inten > hi) begin hi = inten; hi_i = k; end
      end
      for (int ch = 0; ch < 3; ch++)
        s[ch] -= px_chan(win[lo_i], ch) + px_chan(win[hi_i], ch);
    end
    for (int ch = 0; ch < 3; ch++)
      res[8*ch +: 8] = scale_clamp(s[ch], dv);
    return res;
  endfunction

  // Advance the shadow filter by one accepted input beat.
  task automatic filter_step(logic [23:0] px_in, logic fl);
    int unsigned dim, lead, area, c, p, q, qr, qc;
    logic [23:0] px, res;
    bit emit;
    pix_res_t pr;
    dim = sh_size; lead = dim + 1; area = dim * dim;
    px = fl ? 24'd0 : px_in;
    c = col_n % 1024;
    if (fl && owed_n == 0) return;
    for (int k = 0; k < 9; k += 3) begin
      win[k] = win[k + 1];
      win[k + 1] = win[k + 2];
    end
    win[2] = ls_b[c];
    win[5] = ls_a[c];
    win[8] = px;
    if (!fl) begin
      ls_b[c] = ls_a[c];
      ls_a[c] = px;
    end
    emit = fl ? 1'b1 : (owed_n >= lead);
    if (!fl && !emit) owed_n++;
    p = (row_n * dim + col_n) % area;
    q = (p >= lead) ? p - lead : p + area - lead;
    col_n++;
    if (col_n >= dim) begin
      col_n = 0;
      row_n++;
      if (row_n >= dim) row_n = 0;
    end
    if (fl) begin
      owed_n--;
      if (owed_n == 0) begin row_n = 0; col_n = 0; end
    end
    if (!emit) return;
    qr = q / dim; qc = q % dim;
    if (qr >= 1 && qr + 2 <= dim && qc >= 1 && qc + 2 <= dim) res = window_sum();
    else res = win[4];
    pr.r = res[7:0]; pr.g = res[15:8]; pr.b = res[23:16];
    pr.fe = (q == area - 1);
    result_q.push_back(pr);
  endtask

  // One register write over the configuration port, mirrored in the shadow.
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    logic [10:0] v;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SIZE: begin
        v = val[10:0];
        if (v < 3) v = 3;
        if (v > 1024) v = 1024;
        sh_size = v; row_n = 0; col_n = 0; owed_n = 0;
      end
      REG_KTOP: sh_krow[0] = val[23:0];
      REG_KMID: sh_krow[1] = val[23:0];
      REG_KBOT: sh_krow[2] = val[23:0];
      REG_DIV:  sh_div = val[7:0];
      REG_EXT:  sh_ext = val[0];
      default: ;
    endcase
  endtask

  // Present one input beat, wait for acceptance.
  task automatic send_beat(logic [23:0] px, logic fl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= px[7:0]; in_green <= px[15:8]; in_blue <= px[23:16];
    is_flush <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_step(px, fl);
  endtask

  // Wait until every owed result is back, plus slack for a busy block.
  task automatic drain_wait();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Send one frame of random pixels followed by its flush tail.
  task automatic send_frame(int dim, int mode);
    logic [23:0] px;
    for (int i = 0; i < dim * dim; i++) begin
      case (mode)
        0: px = $urandom;
        1: px = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        default: px = {3{8'($urandom_range(100, 104))}};
      endcase
      send_beat(px, 1'b0);
    end
    for (int i = 0; i < dim + 1; i++) send_beat(24'd0, 1'b1);
  endtask

  // Receiver: random stalls, one long hold-off when asked.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        gap = 400;
        hold_off = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 12);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each output beat against the oldest expected result.
  always @(posedge clk) begin
    pix_res_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat %h %h %h fe=%b", $time,
                 out_red, out_green, out_blue, frame_end);
        err_cnt++;
      end else begin
        exp_r = result_q.pop_front();
        if (exp_r.r !== out_red) begin
          $display("%0t: out_red expected %h actual %h", $time, exp_r.r, out_red);
          err_cnt++;
        end
        if (exp_r.g !== out_green) begin
          $display("%0t: out_green expected %h actual %h", $time, exp_r.g, out_green);
          err_cnt++;
        end
        if (exp_r.b !== out_blue) begin
          $display("%0t: out_blue expected %h actual %h", $time, exp_r.b, out_blue);
          err_cnt++;
        end
        if (exp_r.fe !== frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time, exp_r.fe, frame_end);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or configuration access.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    dir_row_t dir_tab [12];
    pix_res_t pr;
    int dim;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_red = 0; in_green = 0; in_blue = 0; is_flush = 0;
    err_cnt = 0; hold_off = 0; no_gaps = 0;
    sh_size = 3; sh_krow = '{24'd0, 24'd0, 24'd0}; sh_div = 1; sh_ext = 0;
    row_n = 0; col_n = 0; owed_n = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < 1024; i++) begin ls_a[i] = '0; ls_b[i] = '0; end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a 3x3 frame after reset with zero kernel, its flush tail and
    // then a stray flush. Only the centre is interior; its result is released
    // by the ninth beat and comes out as zero.
    for (int i = 0; i < 12; i++) begin
      dir_tab[i] = '0;
      dir_tab[i].r = (i == 0) ? 8'hFF : 8'(i * 20);
      dir_tab[i].g = (i == 8) ? 8'hFF : 8'(255 - i * 20);
      dir_tab[i].b = (i == 4) ? 8'h00 : 8'(i * 7);
      dir_tab[i].fl = (i >= 9);
    end
    dir_tab[8].known = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_beat({dir_tab[i].b, dir_tab[i].g, dir_tab[i].r}, dir_tab[i].fl);
      if (dir_tab[i].known) begin
        pr = result_q[$];
        if ((result_q.size() == 0) || (pr !== dir_tab[i].res)) begin
          $display("%0t: directed row %0d expected %h actual %h", $time, i,
                   dir_tab[i].res, pr);
          err_cnt++;
        end
      end
    end
    send_beat(24'h123456, 1'b1);
    send_beat(24'h123456, 1'b1);
    drain_wait();

    // Size clamping, extreme kernels, divisor zero and extremum filter.
    reg_write(REG_SIZE, 32'd0);
    reg_write(REG_KTOP, 32'h7F7F7F);
    reg_write(REG_KMID, 32'h7F7F7F);
    reg_write(REG_KBOT, 32'h7F7F7F);
    reg_write(REG_DIV, 32'd0);
    reg_write(REG_EXT, 32'd1);
    send_frame(3, 0);
    drain_wait();
    reg_write(REG_KTOP, 32'h808080);
    reg_write(REG_KMID, 32'h80FF80);
    reg_write(REG_KBOT, 32'h808080);
    reg_write(REG_DIV, 32'd255);
    send_frame(3, 1);
    drain_wait();
    reg_write(REG_EXT, 32'd0);
    reg_write(REG_SIZE, 32'd2047);
    reg_write(REG_SIZE, 32'd4);
    send_frame(4, 2);
    drain_wait();

    // Random phases: small sizes, back-to-back frames, random kernels.
    for (int ph = 0; ph < 3; ph++) begin
      dim = $urandom_range(3, 6);
      reg_write(REG_SIZE, dim);
      reg_write(REG_KTOP, $urandom);
      reg_write(REG_KMID, $urandom);
      reg_write(REG_KBOT, $urandom);
      reg_write(REG_DIV, $urandom_range(0, 255));
      reg_write(REG_EXT, $urandom_range(0, 1));
      no_gaps = (ph == 1);
      if (ph == 2) hold_off = 1'b1;
      for (int i = 0; i < dim * dim; i++) send_beat($urandom, 1'b0);
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < dim * dim; i++) send_beat($urandom, ($urandom_range(0, 9) == 0));
      for (int i = 0; i < dim + 1 + $urandom_range(0, 2); i++) send_beat($urandom, 1'b1);
      drain_wait();
    end
    no_gaps = 0;

    // One phase at the largest size and a mid-frame size write.
    reg_write(REG_SIZE, 32'd1024);
    reg_write(REG_KMID, 32'h000100);
    reg_write(REG_DIV, 32'd1);
    for (int i = 0; i < 1030; i++) send_beat($urandom, 1'b0);
    drain_wait();
    reg_write(REG_SIZE, 32'd1024);
    drain_wait();

    if (err_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/rcef_pkg.sv
design/rcef_regs.sv
design/rcef_ctrl.sv
design/rcef_dp.sv
design/rgb_conv3x3_extremum_filter.sv
tb/tb_rgb_conv3x3_extremum_filter.sv
